@@ sv/tqkc_pkg.sv @@
// ----------------------------------------------------------------------------
// tqkc_pkg
// Shared types and constants of the quadratic-key Trithemius cipher core.
// ----------------------------------------------------------------------------
package tqkc_pkg;

	localparam int ALPHABET_SIZE  = 28;
	localparam int POSITION_WIDTH = 16;

	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 5;
	localparam int WORD_W      = 32;
	localparam int WORD_COUNT  = 7;
	localparam int ENTRY_COUNT = WORD_COUNT * (WORD_W / CHAR_W);
	localparam int ENTRY_IDX_W = $clog2(ENTRY_COUNT);

	// largest length that both the parameter and the stored entries allow
	localparam int USABLE_LEN = (ALPHABET_SIZE < ENTRY_COUNT) ? ALPHABET_SIZE : ENTRY_COUNT;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// remainder unit: six dividend bits per step
	localparam int DIGIT_W    = 6;
	localparam int KEY_STEPS  = 2;
	localparam int KEY_PAD_W  = KEY_STEPS * DIGIT_W;
	localparam int POS_STEPS  = (POSITION_WIDTH + DIGIT_W - 1) / DIGIT_W;
	localparam int DIV_W      = POS_STEPS * DIGIT_W;
	localparam int STEP_CNT_W = $clog2((POS_STEPS > KEY_STEPS) ? POS_STEPS : KEY_STEPS);

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	typedef logic [WORD_W-1:0]    word_t;

	localparam reg_idx_t REG_LENGTH    = 3'd0;
	localparam reg_idx_t REG_WORD_BASE = 3'd1;

	localparam logic [LEN_W-1:0] RESET_LENGTH = 5'd26;
	localparam word_t RESET_WORDS [WORD_COUNT] = '{
		32'h4443_4241, 32'h4847_4645, 32'h4C4B_4A49, 32'h504F_4E4D,
		32'h5453_5251, 32'h5857_5655, 32'h0000_5A59
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEY,
		ST_FIN,
		ST_RMOD
	} state_t;

	typedef struct packed {
		logic cfg_write;
		logic item_accept;
		logic pos_load;
		logic mod_step;
		logic r_commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic skip;
	} sts_t;

endpackage

@@ sv/tqkc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tqkc_ctrl
// Sequencer: handshakes, remainder step count and result hand-off.
// ----------------------------------------------------------------------------
module tqkc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tqkc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  tqkc_pkg::sts_t                sts,
	output tqkc_pkg::cmd_t                cmd
);

	tqkc_pkg::state_t                    state_q, state_d;
	logic [tqkc_pkg::STEP_CNT_W-1:0]     cnt_q;
	logic                                out_valid_q;
	logic                                cfg_fire, in_fire, out_free, len_write;
	logic                                key_last, pos_last;

	assign cfg_ready = (state_q == tqkc_pkg::ST_IDLE);
	assign in_stall  = (state_q != tqkc_pkg::ST_IDLE) || cfg_valid;
	assign out_valid = out_valid_q;

	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign len_write = cfg_fire && (cfg_index == tqkc_pkg::REG_LENGTH);
	assign key_last  = (cnt_q == tqkc_pkg::STEP_CNT_W'(tqkc_pkg::KEY_STEPS - 1));
	assign pos_last  = (cnt_q == tqkc_pkg::STEP_CNT_W'(tqkc_pkg::POS_STEPS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			tqkc_pkg::ST_IDLE: begin
				if (len_write)
					state_d = tqkc_pkg::ST_RMOD;
				else if (in_fire)
					state_d = tqkc_pkg::ST_KEY;
			end
			tqkc_pkg::ST_KEY: begin
				if (sts.skip || key_last)
					state_d = tqkc_pkg::ST_FIN;
			end
			tqkc_pkg::ST_FIN: begin
				if (out_free)
					state_d = tqkc_pkg::ST_IDLE;
			end
			tqkc_pkg::ST_RMOD: begin
				if (pos_last)
					state_d = tqkc_pkg::ST_IDLE;
			end
			default: state_d = tqkc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.cfg_write   = cfg_fire;
		cmd.item_accept = in_fire;
		cmd.pos_load    = len_write;
		case (state_q)
			tqkc_pkg::ST_KEY:  cmd.mod_step = !sts.skip;
			tqkc_pkg::ST_RMOD: begin
				cmd.mod_step = 1'b1;
				cmd.r_commit = pos_last;
			end
			tqkc_pkg::ST_FIN:  cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tqkc_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// restart the step count on every state change
			if (state_d != state_q)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ sv/tqkc_datapath.sv @@
// ----------------------------------------------------------------------------
// tqkc_datapath
// Alphabet registers, search, position tracking, shared remainder unit and
// result register.
// ----------------------------------------------------------------------------
module tqkc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tqkc_pkg::cmd_t                 cmd,
	output tqkc_pkg::sts_t                 sts,
	input  logic [tqkc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tqkc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [tqkc_pkg::CHAR_W-1:0]     char_in,
	input  logic                           mode,
	input  logic                           message_start,
	output logic [tqkc_pkg::CHAR_W-1:0]     char_out,
	output logic                           was_substituted
);

	localparam int LW = tqkc_pkg::LEN_W;
	localparam int CW = tqkc_pkg::CHAR_W;
	localparam int PW = tqkc_pkg::POSITION_WIDTH;
	localparam int IW = tqkc_pkg::ENTRY_IDX_W;

	logic [LW-1:0]              len_q;
	tqkc_pkg::word_t            words_q [tqkc_pkg::WORD_COUNT];
	logic [CW-1:0]              entry [tqkc_pkg::ENTRY_COUNT];
	logic [LW-1:0]              use_len;

	logic [PW-1:0]              pos_q, pos_eff;
	logic [LW-1:0]              r_q, r_eff, r_next;
	logic [LW:0]                r_inc;

	logic                       hit;
	logic [IW-1:0]              hit_idx;
	logic [LW:0]                fac_a, fac_b;
	logic [tqkc_pkg::KEY_PAD_W-1:0] product;

	logic [tqkc_pkg::DIV_W-1:0] dv_q;
	logic [LW-1:0]              rem_q, rem_next;

	logic [CW-1:0]              char_q;
	logic                       mode_q, found_q;
	logic [IW-1:0]              p_q;
	logic [LW:0]                sum, diff, idx_w;
	logic [IW-1:0]              idx;
	logic [CW-1:0]              sub_char;
	logic [CW-1:0]              char_out_q;
	logic                       subst_q;

	// alphabet registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= tqkc_pkg::RESET_LENGTH;
			for (int w = 0; w < tqkc_pkg::WORD_COUNT; w++)
				words_q[w] <= tqkc_pkg::RESET_WORDS[w];
		end else if (cmd.cfg_write) begin
			if (cfg_index == tqkc_pkg::REG_LENGTH)
				len_q <= cfg_data[LW-1:0];
			else
				words_q[cfg_index - tqkc_pkg::REG_WORD_BASE] <= cfg_data;
		end
	end

	for (genvar j = 0; j < tqkc_pkg::ENTRY_COUNT; j++) begin : g_entry
		assign entry[j] = words_q[j / 4][(j % 4) * CW +: CW];
	end

	assign use_len = (len_q > LW'(tqkc_pkg::USABLE_LEN)) ? LW'(tqkc_pkg::USABLE_LEN) : len_q;

	// first match among the entries in use
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int j = tqkc_pkg::ENTRY_COUNT - 1; j >= 0; j--) begin
			if ((IW'(j) < use_len) && (entry[j] == char_in)) begin
				hit     = 1'b1;
				hit_idx = IW'(j);
			end
		end
	end

	// r tracks position mod length so the key needs no wide reduction
	assign pos_eff = message_start ? '0 : pos_q;
	assign r_eff   = message_start ? '0 : r_q;
	assign r_inc   = {1'b0, r_eff} + 1'b1;
	assign r_next  = ((&pos_eff) || (r_inc >= {1'b0, use_len})) ? '0 : r_inc[LW-1:0];

	// 2r^2 + 5r + 3 = (r + 1)(2r + 3)
	assign fac_a   = {1'b0, r_eff} + 1'b1;
	assign fac_b   = {r_eff, 1'b0} + (LW+1)'(3);
	assign product = tqkc_pkg::KEY_PAD_W'(fac_a * fac_b);

	// restoring remainder, one digit of the dividend per step
	always_comb begin
		logic [LW-1:0]               t;
		logic [LW:0]                 tw;
		logic [tqkc_pkg::DIGIT_W-1:0] d;
		t = rem_q;
		d = dv_q[tqkc_pkg::DIV_W-1 -: tqkc_pkg::DIGIT_W];
		for (int b = tqkc_pkg::DIGIT_W - 1; b >= 0; b--) begin
			tw = {t, d[b]};
			if (tw >= {1'b0, use_len})
				tw = tw - {1'b0, use_len};
			t = tw[LW-1:0];
		end
		rem_next = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			r_q   <= '0;
		end else if (cmd.item_accept) begin
			pos_q <= pos_eff + 1'b1;
			r_q   <= r_next;
		end else if (cmd.r_commit) begin
			r_q   <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_accept) begin
			dv_q    <= {product, {(tqkc_pkg::DIV_W - tqkc_pkg::KEY_PAD_W){1'b0}}};
			rem_q   <= '0;
			char_q  <= char_in;
			mode_q  <= mode;
			found_q <= hit;
			p_q     <= hit_idx;
		end else if (cmd.pos_load) begin
			dv_q    <= tqkc_pkg::DIV_W'(pos_q);
			rem_q   <= '0;
		end else if (cmd.mod_step) begin
			dv_q    <= dv_q << tqkc_pkg::DIGIT_W;
			rem_q   <= rem_next;
		end
	end

	// shift the matched index by the key, wrapping at the length in use
	assign sum  = {1'b0, p_q} + {1'b0, rem_q};
	assign diff = {1'b0, p_q} - {1'b0, rem_q};
	always_comb begin
		if (mode_q)
			idx_w = diff[LW] ? (diff + {1'b0, use_len}) : diff;
		else
			idx_w = (sum >= {1'b0, use_len}) ? (sum - {1'b0, use_len}) : sum;
		idx = idx_w[IW-1:0];
	end
	assign sub_char = (idx < IW'(tqkc_pkg::ENTRY_COUNT)) ? entry[idx] : '0;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			char_out_q <= found_q ? sub_char : char_q;
			subst_q    <= found_q;
		end
	end

	assign sts.skip        = !found_q;
	assign char_out        = char_out_q;
	assign was_substituted = subst_q;

endmodule

@@ sv/trithemius_quadratic_key_cipher_core.sv @@
// ----------------------------------------------------------------------------
// trithemius_quadratic_key_cipher_core
// Byte-wide Trithemius substitution with a quadratic running key.
// ----------------------------------------------------------------------------
// An item whose character is in the alphabet passes through the accept cycle
// (search and key product), two steps of the shared remainder unit that
// reduce the key by the alphabet length, and the result load, which waits
// for the output register to be free. A character not in the alphabet skips
// the remainder steps. The next item can be taken in the cycle after the
// result load, unless a configuration write is pending, even while that
// result still waits in the output register. A write to the length register
// starts a pass of the same remainder unit that re-derives the position
// modulo the new length; input stalls during that pass.
module trithemius_quadratic_key_cipher_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tqkc_pkg::CHAR_W-1:0]     char_in,
	input  logic                           mode,
	input  logic                           message_start,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tqkc_pkg::CHAR_W-1:0]     char_out,
	output logic                           was_substituted,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tqkc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tqkc_pkg::CFG_DATA_W-1:0] cfg_data
);

	tqkc_pkg::cmd_t cmd;
	tqkc_pkg::sts_t sts;

	tqkc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.sts       (sts),
		.cmd       (cmd)
	);

	tqkc_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.char_in         (char_in),
		.mode            (mode),
		.message_start   (message_start),
		.char_out        (char_out),
		.was_substituted (was_substituted)
	);

endmodule

@@ sv/tqkc_checker.sv @@
// ----------------------------------------------------------------------------
// tqkc_checker
// Port-level checks of the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module tqkc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [tqkc_pkg::CHAR_W-1:0]     char_out,
	input logic                           was_substituted,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [tqkc_pkg::CFG_IDX_W-1:0]  cfg_index
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(was_substituted))
		else $error("stalled result changed");

	// an accepted item keeps the input stalled while it is worked on
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while another is in flight");

	// a length write starts the position recompute
	a_len_recompute: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == tqkc_pkg::REG_LENGTH) |=> in_stall)
		else $error("input open during position recompute");

	// a result only appears from an item in flight
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in flight");

endmodule

bind trithemius_quadratic_key_cipher_core tqkc_checker u_tqkc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.char_out        (char_out),
	.was_substituted (was_substituted),
	.cfg_valid       (cfg_valid),
	.cfg_ready       (cfg_ready),
	.cfg_index       (cfg_index)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadratic-key Trithemius cipher core. Items are
// driven through the valid/stall channels with random gaps and output
// stalls. A scoreboard tracks the alphabet registers and position counter,
// predicts every substituted character, and compares each result in order.
// Directed items cover the alphabet edges, zero and oversized lengths, zero
// and duplicate entries. Random phases reload the alphabet and send text.
// A final burst runs with no gaps on either side.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	localparam int STALL_PERCENT   = 24;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DEAD_LIMIT      = 2000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int PHASE_COUNT     = 10;
	localparam int PHASE_ITEMS     = 180;
	localparam int BURST_ITEMS     = 130;

	localparam int CW = tqkc_pkg::CHAR_W;

	typedef struct packed {
		logic [CW-1:0] ch;
		logic          sub;
	} cipher_out_t;

	class substitution_tracker;
		logic [tqkc_pkg::LEN_W-1:0]          length_reg;
		tqkc_pkg::word_t                     words [tqkc_pkg::WORD_COUNT];
		logic [tqkc_pkg::POSITION_WIDTH-1:0] position;
		cipher_out_t                         expected_chars [$];
		int                                  mismatches;

		function new();
			length_reg = 5'd26;
			words[0] = 32'h4443_4241;
			words[1] = 32'h4847_4645;
			words[2] = 32'h4C4B_4A49;
			words[3] = 32'h504F_4E4D;
			words[4] = 32'h5453_5251;
			words[5] = 32'h5857_5655;
			words[6] = 32'h0000_5A59;
			position = '0;
			mismatches = 0;
		endfunction

		function void write_reg(tqkc_pkg::reg_idx_t idx, tqkc_pkg::word_t data);
			if (idx == tqkc_pkg::REG_LENGTH)
				length_reg = data[tqkc_pkg::LEN_W-1:0];
			else
				words[idx - tqkc_pkg::REG_WORD_BASE] = data;
		endfunction

		// entries in use: clamp to the parameter and to what the words hold
		function int unsigned span();
			int unsigned len;
			len = 32'(length_reg);
			if (len > tqkc_pkg::ALPHABET_SIZE)
				len = tqkc_pkg::ALPHABET_SIZE;
			if (len > tqkc_pkg::WORD_COUNT * 4)
				len = tqkc_pkg::WORD_COUNT * 4;
			return len;
		endfunction

		function logic [CW-1:0] entry(int unsigned i);
			tqkc_pkg::word_t w;
			w = words[i / 4];
			return w[(i % 4) * 8 +: 8];
		endfunction

		function cipher_out_t substitute(logic [CW-1:0] c, logic decrypt, logic start);
			cipher_out_t res;
			int unsigned len, p, r, k, idx;
			logic found;
			if (start)
				position = '0;
			len = span();
			res.ch = c;
			res.sub = 1'b0;
			found = 1'b0;
			for (p = 0; p < len && !found; p++) begin
				if (entry(p) == c) begin
					r = position % len;
					k = (2 * r * r + 5 * r + 3) % len;
					idx = (decrypt == MODE_DECRYPT) ? (p + len - k) % len : (p + k) % len;
					res.ch = entry(idx);
					res.sub = 1'b1;
					found = 1'b1;
				end
			end
			position = position + 1'b1;
			return res;
		endfunction

		function void note_char(logic [CW-1:0] c, logic decrypt, logic start);
			expected_chars.push_back(substitute(c, decrypt, start));
		endfunction

		task report(string what);
			mismatches++;
			$display("%0t mismatch: %s", $realtime, what);
		endtask

		task check_result(logic [CW-1:0] ch, logic sub);
			cipher_out_t want;
			if (expected_chars.size() == 0) begin
				report($sformatf("result %h with no item pending", ch));
				return;
			end
			want = expected_chars.pop_front();
			if (ch !== want.ch)
				report($sformatf("char_out %h, expected %h", ch, want.ch));
			if (sub !== want.sub)
				report($sformatf("was_substituted %b, expected %b", sub, want.sub));
		endtask

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [CW-1:0]                     char_in = '0;
	logic                              mode = MODE_ENCRYPT;
	logic                              message_start = 1'b0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [CW-1:0]                     char_out;
	logic                              was_substituted;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	tqkc_pkg::reg_idx_t                cfg_index = '0;
	logic [tqkc_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

	substitution_tracker tracker = new();

	logic no_gaps = 1'b0;
	logic msg_mode = MODE_ENCRYPT;
	int   hold_order = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   dead_cycles = 0;

	trithemius_quadratic_key_cipher_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.char_in         (char_in),
		.mode            (mode),
		.message_start   (message_start),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.char_out        (char_out),
		.was_substituted (was_substituted),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			tracker.check_result(char_out, was_substituted);
	end

	// receiver: long hold-off on request, otherwise random stalls unless no_gaps is set
	always @(negedge clk) begin
		if (hold_order != hold_seen) begin
			hold_seen = hold_order;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= !no_gaps && ($urandom_range(99) < STALL_PERCENT);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			dead_cycles <= 0;
		else if (dead_cycles == DEAD_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else
			dead_cycles <= dead_cycles + 1;
	end

	// leaves in_valid high at the falling edge after the item is taken
	task automatic send_char(input logic [CW-1:0] c, input logic m, input logic s);
		if (!no_gaps) begin
			while ($urandom_range(99) < STALL_PERCENT) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		char_in <= c;
		mode <= m;
		message_start <= s;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		tracker.note_char(c, m, s);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input tqkc_pkg::reg_idx_t idx, input tqkc_pkg::word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		tracker.write_reg(idx, data);
		@(negedge clk);
	endtask

	function automatic logic [CW-1:0] pick_char();
		int unsigned len;
		len = tracker.span();
		if (len != 0 && $urandom_range(99) < 80)
			return tracker.entry($urandom_range(len - 1));
		return CW'($urandom_range(255));
	endfunction

	// reload every word, then the length; forced_len < 0 picks one at random
	task automatic random_alphabet(input int forced_len);
		logic [7:0]      base, step;
		tqkc_pkg::word_t w;
		logic            distinct;
		int              n, b, len;
		if (forced_len >= 0)
			len = forced_len;
		else begin
			case ($urandom_range(9))
				0: len = 0;
				1: len = 1;
				2: len = 28;
				3: len = int'($urandom_range(29, 31));
				4: len = 26;
				default: len = int'($urandom_range(2, 27));
			endcase
		end
		distinct = (forced_len >= 0) || ($urandom_range(99) < 80);
		base = 8'($urandom_range(255));
		step = 8'($urandom_range(255)) | 8'd1;
		for (n = 0; n < tqkc_pkg::WORD_COUNT; n++) begin
			if (distinct) begin
				for (b = 0; b < 4; b++)
					w[b * 8 +: 8] = 8'(base + step * (4 * n + b));
			end else begin
				w = $urandom;
				if ($urandom_range(99) < 15)
					w = {4{w[7:0]}};
			end
			write_reg(tqkc_pkg::reg_idx_t'(tqkc_pkg::REG_WORD_BASE + n), w);
		end
		write_reg(tqkc_pkg::REG_LENGTH, ($urandom & ~32'h1F) | 32'(len));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_text(input int count);
		logic start;
		int   i;
		for (i = 0; i < count; i++) begin
			start = ($urandom_range(99) < 4);
			if (start)
				msg_mode = 1'($urandom_range(1));
			else if ($urandom_range(99) < 5)
				msg_mode = !msg_mode;
			send_char(pick_char(), msg_mode, start);
		end
	endtask

	initial begin
		int phase, n;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset alphabet: both ends, lowercase and bytes outside it
		send_char("A", MODE_ENCRYPT, 1'b1);
		send_char("Z", MODE_ENCRYPT, 1'b0);
		send_char("Z", MODE_DECRYPT, 1'b0);
		send_char("M", MODE_DECRYPT, 1'b0);
		send_char(8'h00, MODE_ENCRYPT, 1'b0);
		send_char(8'hFF, MODE_DECRYPT, 1'b0);
		send_char("a", MODE_ENCRYPT, 1'b0);

		// full length brings the two zero entries into play
		wait_drained();
		write_reg(tqkc_pkg::REG_LENGTH, 32'd28);
		cfg_valid <= 1'b0;
		send_char(8'h00, MODE_ENCRYPT, 1'b1);
		send_char(8'h00, MODE_DECRYPT, 1'b0);
		send_char("Y", MODE_ENCRYPT, 1'b0);

		// duplicate entries, length past the end
		wait_drained();
		write_reg(tqkc_pkg::REG_WORD_BASE, 32'h4141_4141);
		write_reg(tqkc_pkg::REG_LENGTH, 32'd31);
		cfg_valid <= 1'b0;
		send_char("A", MODE_ENCRYPT, 1'b1);
		send_char("A", MODE_DECRYPT, 1'b0);
		send_char("B", MODE_ENCRYPT, 1'b0);

		// zero length: everything passes through
		wait_drained();
		write_reg(tqkc_pkg::REG_LENGTH, 32'd0);
		cfg_valid <= 1'b0;
		send_char("E", MODE_ENCRYPT, 1'b0);
		send_char(8'h00, MODE_DECRYPT, 1'b1);

		wait_drained();
		write_reg(tqkc_pkg::REG_WORD_BASE, 32'h0000_00FF);
		write_reg(tqkc_pkg::REG_LENGTH, 32'd1);
		cfg_valid <= 1'b0;
		send_char(8'hFF, MODE_ENCRYPT, 1'b0);
		send_char(8'hFF, MODE_DECRYPT, 1'b0);

		wait_drained();
		for (n = 0; n < tqkc_pkg::WORD_COUNT; n++)
			write_reg(tqkc_pkg::reg_idx_t'(tqkc_pkg::REG_WORD_BASE + n),
				n[0] ? 32'h0000_0000 : 32'hFFFF_FFFF);
		write_reg(tqkc_pkg::REG_LENGTH, 32'hFFFF_FFFC);
		cfg_valid <= 1'b0;
		send_char(8'hFF, MODE_ENCRYPT, 1'b1);
		send_char(8'h00, MODE_DECRYPT, 1'b0);
		send_char(8'hFF, MODE_DECRYPT, 1'b0);

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			wait_drained();
			random_alphabet(-1);
			if (phase == 3) begin
				// hold the output long enough to back up the input side
				run_text(60);
				hold_order <= hold_order + 1;
				run_text(PHASE_ITEMS - 60);
			end else if (phase == 6) begin
				run_text(100);
				wait_drained();
				run_text(PHASE_ITEMS - 100);
			end else
				run_text(PHASE_ITEMS);
		end

		// one burst with no gaps on either side
		wait_drained();
		random_alphabet(27);
		no_gaps <= 1'b1;
		run_text(BURST_ITEMS);

		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
